/* sv/ewbw_pkg.sv */
// shared types and constants for the energy window blend weight block
`default_nettype none
package ewbw_pkg;
    localparam int unsigned EW = 24;
    localparam int unsigned WW = 17;
    localparam int unsigned QW = 17;
    localparam logic [WW-1:0] ONE_Q16 = 17'd65536;
    localparam int unsigned NREGS = 7;
    localparam logic [2:0] RAMP_REG = 3'd6;
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned NUMW = 27;
    localparam int unsigned DENW = 26;

    typedef struct packed {
        logic          en;
        logic          hard;
        logic          in_win;
        logic          rz;
        logic          fz;
        logic          rs;
        logic          fs;
        logic [NUMW-1:0] rr;
        logic [NUMW-1:0] fr;
        logic [QW-1:0] rq;
        logic [QW-1:0] fq;
    } div_lane_t;
endpackage
`default_nettype wire

/* sv/energy_window_blend_weight_top.sv */
// top level of the energy window blend weight block
`default_nettype none
// Weighs one unsigned Q8.16 energy per cycle against up to three energy
// windows and returns a Q1.16 blend weight (65536 is one). Each window lane
// is a chain of seventeen identical division cells, one quotient bit per
// cell, that computes the rising and falling ramp positions side by side;
// two multiply stages form the smoothstep and one more the window product,
// and a final stage takes the maximum over the enabled windows. A new energy
// is taken every cycle in which in_stall is low. The whole pipeline advances
// only when the output register is empty or being drained, so in_stall
// follows out_stall while the output holds a result. Configuration writes
// are always taken (cfg_ready is high); indexes above 6 are ignored.
module energy_window_blend_weight_top #(
    parameter int unsigned NUM_WINDOWS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [23:0] energy,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [16:0]      weight,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    // register file
    logic [23:0] regs_reg [ewbw_pkg::NREGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ewbw_pkg::NREGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index <= ewbw_pkg::RAMP_REG))
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // pipeline moves when the output slot is free or being taken
    logic adv;
    logic out_valid_reg;
    logic [16:0] weight_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    logic                 lv   [NUM_WINDOWS];
    logic                 len  [NUM_WINDOWS];
    logic [16:0]          lw   [NUM_WINDOWS];

    genvar g;
    generate
        for (g = 0; g < NUM_WINDOWS; g++)
        begin : g_win
            ewbw_window_cell u_win (
                .clk    (clk),
                .rst_n  (rst_n),
                .adv    (adv),
                .vin    (in_valid),
                .energy (energy),
                .lo     (regs_reg[2*g]),
                .hi     (regs_reg[2*g+1]),
                .width  (regs_reg[ewbw_pkg::RAMP_REG]),
                .vout   (lv[g]),
                .en_out (len[g]),
                .wout   (lw[g])
            );
        end
    endgenerate

    // maximum over enabled windows, one if none is enabled
    logic [16:0] best;
    logic any;

    always_comb
    begin
        best = '0;
        any  = 1'b0;
        for (int i = 0; i < NUM_WINDOWS; i++)
        begin
            if (len[i])
            begin
                any = 1'b1;
                if (lw[i] > best)
                begin
                    best = lw[i];
                end
            end
        end
        if (!any)
        begin
            best = ewbw_pkg::ONE_Q16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= lv[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            weight_reg <= best;
        end
    end

    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;
endmodule
`default_nettype wire

/* sv/ewbw_div_cell.sv */
// one restoring division cell: one quotient bit for the rising and falling ramp
`default_nettype none
module ewbw_div_cell #(
    parameter int unsigned BIT = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          vin,
    input  wire logic [ewbw_pkg::DENW-1:0]     den,
    input  wire logic [ewbw_pkg::DENW-1:0]     den_out_src,
    input  wire ewbw_pkg::div_lane_t           din,
    output logic                               vout,
    output logic [ewbw_pkg::DENW-1:0]          den_out,
    output ewbw_pkg::div_lane_t                dout
);
    // remainder arrives already doubled; trial subtract, then double again
    logic [ewbw_pkg::NUMW-1:0] dext;
    logic [ewbw_pkg::NUMW-1:0] rrem, frem;
    logic rbit, fbit;
    ewbw_pkg::div_lane_t n_next;
    logic vout_reg;

    always_comb
    begin
        dext = {{(ewbw_pkg::NUMW-ewbw_pkg::DENW){1'b0}}, den};
        n_next = din;
        rbit = (din.rr >= dext);
        fbit = (din.fr >= dext);
        rrem = rbit ? (din.rr - dext) : din.rr;
        frem = fbit ? (din.fr - dext) : din.fr;
        n_next.rr = {rrem[ewbw_pkg::NUMW-2:0], 1'b0};
        n_next.fr = {frem[ewbw_pkg::NUMW-2:0], 1'b0};
        n_next.rq[BIT] = rbit;
        n_next.fq[BIT] = fbit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (adv)
        begin
            vout_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dout     <= n_next;
            den_out  <= den_out_src;
        end
    end

    assign vout = vout_reg;
endmodule
`default_nettype wire

/* sv/ewbw_window_cell.sv */
// one window lane: front end, chain of division cells, smoothstep and product
`default_nettype none
module ewbw_window_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic                    vin,
    input  wire logic [ewbw_pkg::EW-1:0] energy,
    input  wire logic [ewbw_pkg::EW-1:0] lo,
    input  wire logic [ewbw_pkg::EW-1:0] hi,
    input  wire logic [ewbw_pkg::EW-1:0] width,
    output logic                         vout,
    output logic                         en_out,
    output logic [ewbw_pkg::WW-1:0]      wout
);
    localparam int unsigned N = ewbw_pkg::DIV_STEPS;
    localparam int unsigned NW = ewbw_pkg::NUMW;
    localparam int unsigned DW = ewbw_pkg::DENW;

    // front-end signed numerators, two's complement
    logic signed [27:0] rnum, fnum;
    logic signed [27:0] sat_lim;
    ewbw_pkg::div_lane_t f_lane;
    logic [DW-1:0] f_den;

    always_comb
    begin
        rnum = $signed({3'b0, energy, 1'b0}) - $signed({3'b0, lo, 1'b0})
             + $signed({4'b0, width});
        fnum = $signed({3'b0, hi, 1'b0}) + $signed({4'b0, width})
             - $signed({3'b0, energy, 1'b0});
        // numerator at or above twice the divisor means a position past one
        sat_lim       = $signed({2'b0, width, 2'b0});
        f_lane.en     = hi > lo;
        f_lane.hard   = width == '0;
        f_lane.in_win = (energy >= lo) && (energy <= hi);
        f_lane.rz     = rnum <= 0;
        f_lane.fz     = fnum <= 0;
        f_lane.rs     = rnum >= sat_lim;
        f_lane.fs     = fnum >= sat_lim;
        // below saturation the numerator is under twice the divisor,
        // so seventeen quotient bits are exact
        f_lane.rr     = rnum[NW-1:0];
        f_lane.fr     = fnum[NW-1:0];
        f_lane.rq     = '0;
        f_lane.fq     = '0;
        f_den         = {1'b0, width, 1'b0};
    end

    // stage 0 register
    logic                 v0_reg;
    ewbw_pkg::div_lane_t  l0_reg;
    logic [DW-1:0]        d0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l0_reg <= f_lane;
            d0_reg <= f_den;
        end
    end

    // chain of quotient cells, most significant bit first
    logic                v_c [N+1];
    ewbw_pkg::div_lane_t l_c [N+1];
    logic [DW-1:0]       d_c [N+1];

    assign v_c[0] = v0_reg;
    assign l_c[0] = l0_reg;
    assign d_c[0] = d0_reg;

    // quotient is num*65536/den; cell k decides bit (16-k) by comparing the
    // running remainder, doubled once per cell, against den
    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            ewbw_div_cell #(.BIT(N-1-k)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .adv         (adv),
                .vin         (v_c[k]),
                .den         (d_c[k]),
                .den_out_src (d_c[k]),
                .din         (l_c[k]),
                .vout        (v_c[k+1]),
                .den_out     (d_c[k+1]),
                .dout        (l_c[k+1])
            );
        end
    endgenerate

    // smoothstep stage a: clamp and square
    ewbw_pkg::div_lane_t le;
    logic [16:0] tr, tf;
    logic [33:0] sqr, sqf;
    logic va_reg;
    logic [16:0] tr_reg, tf_reg;
    logic [16:0] sqr_reg, sqf_reg;
    logic en_a_reg, hard_a_reg, in_a_reg;

    always_comb
    begin
        le = l_c[N];
        tr = le.rz ? 17'd0 : (le.rs ? ewbw_pkg::ONE_Q16 : le.rq);
        tf = le.fz ? 17'd0 : (le.fs ? ewbw_pkg::ONE_Q16 : le.fq);
        if (tr > ewbw_pkg::ONE_Q16)
        begin
            tr = ewbw_pkg::ONE_Q16;
        end
        if (tf > ewbw_pkg::ONE_Q16)
        begin
            tf = ewbw_pkg::ONE_Q16;
        end
        sqr = tr * tr;
        sqf = tf * tf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= v_c[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tr_reg     <= tr;
            tf_reg     <= tf;
            sqr_reg    <= sqr[32:16];
            sqf_reg    <= sqf[32:16];
            en_a_reg   <= le.en;
            hard_a_reg <= le.hard;
            in_a_reg   <= le.in_win;
        end
    end

    // stage b: times (3 - 2t)
    logic [17:0] kr, kf;
    logic [34:0] sr, sf;
    logic vb_reg;
    logic [16:0] sr_reg, sf_reg;
    logic en_b_reg, hard_b_reg, in_b_reg;

    always_comb
    begin
        kr = 18'd196608 - {tr_reg, 1'b0};
        kf = 18'd196608 - {tf_reg, 1'b0};
        sr = sqr_reg * kr;
        sf = sqf_reg * kf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_reg     <= sr[32:16];
            sf_reg     <= sf[32:16];
            en_b_reg   <= en_a_reg;
            hard_b_reg <= hard_a_reg;
            in_b_reg   <= in_a_reg;
        end
    end

    // stage c: window product
    logic [33:0] wp;
    logic vc_reg, en_c_reg;
    logic [ewbw_pkg::WW-1:0] w_reg;

    assign wp = sr_reg * sf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            en_c_reg <= en_b_reg;
            if (hard_b_reg)
            begin
                w_reg <= in_b_reg ? ewbw_pkg::ONE_Q16 : '0;
            end
            else
            begin
                w_reg <= wp[32:16];
            end
        end
    end

    assign vout   = vc_reg;
    assign en_out = en_c_reg;
    assign wout   = w_reg;
endmodule
`default_nettype wire
